/* src/cidr_text_parser_defines.svh */
// Assertion macros shared by the cidr_text_parser checker.
// No dependencies.
`ifndef CIDR_TEXT_PARSER_DEFINES_SVH
`define CIDR_TEXT_PARSER_DEFINES_SVH

// clocked check, off while reset is asserted
`define CTP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked check that also holds during reset
`define CTP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/ctp_pkg.sv */
// Types and constants for the CIDR text parser.
// No dependencies.
`timescale 1ns / 1ps
package ctp_pkg;

    // colon run codes
    localparam logic [1:0] CR_NONE   = 2'd0;  // nothing pending
    localparam logic [1:0] CR_SINGLE = 2'd1;  // colon after a group
    localparam logic [1:0] CR_GAP    = 2'd2;  // "::" just seen
    localparam logic [1:0] CR_LEAD   = 2'd3;  // lone leading colon

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [8:0] OCTET_MAX   = 9'd255;
    localparam logic [8:0] DEC_SAT     = 9'd256;
    localparam logic [7:0] PFX_MAX_V6  = 8'd128;
    localparam logic [7:0] PFX_MAX_V4  = 8'd32;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in;

    typedef struct packed {
        logic        ok;
        logic        is_v6;
        logic        pfx_present;
        logic [7:0]  prefix_len;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
    } t_out;

    typedef struct packed {
        logic             in_prefix;
        logic [7:0][15:0] grp;
        logic [3:0]       gc;
        logic             gap;
        logic [3:0]       gp;
        logic [15:0]      hex;
        logic [8:0]       dec;
        logic [2:0]       dc;
        logic             lz;
        logic             nd;
        logic [3:0][7:0]  oct;
        logic [1:0]       oi;
        logic             dotted;
        logic [1:0]       cr;
        logic             sc;
        logic [7:0]       pa;
        logic [1:0]       pd;
        logic             failed;
    } t_state;

endpackage

/* src/cidr_text_parser.sv */
// CIDR text parser top level: character parser with a one-word result register.
// Depends on ctp_pkg.
`timescale 1ns / 1ps
// Usage:
//  - Input channel (i_in_valid / o_in_stall / i_in_data) carries one character
//    word per cycle; i_in_data.last marks the final character of a text.
//  - Output channel (o_out_valid / i_out_stall / o_out_data) carries one result
//    word per text: ok flag, v6 flag, prefix flag and length, 128-bit address.
//    On a failed parse every field but ok reads zero.
//  - Throughput: one character per cycle while o_in_stall is low. The whole state update, the final
//    address check and the "::" expansion are one pass of logic between the
//    state register and the result register.
//  - Latency: the result is valid the cycle after the last character is taken.
//  - Stall: non-last and last characters keep flowing while the result register
//    is free or being drained; o_in_stall rises only while a result is held
//    under i_out_stall. A held result does not change.
//  - Reset (synchronous, active low) clears the parse state and drops any
//    pending result. After each last character the parse state returns to
//    reset, so the next word starts a new text.
module cidr_text_parser
    import ctp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_state r_state, n_state;
    logic   r_out_valid;
    t_out   r_out, n_out;
    logic   in_take;

    function automatic logic octet_ok(input t_state s);
        return (s.dc >= 3'd1) && (s.dc <= 3'd3) && !s.nd &&
               !((s.dc > 3'd1) && s.lz) && (s.dec <= OCTET_MAX);
    endfunction

    function automatic t_state push(input t_state s, input logic [15:0] v);
        t_state so;
        so = s;
        so.grp[s.gc[2:0]] = v;
        so.gc = s.gc + 4'd1;
        return so;
    endfunction

    function automatic t_state clear_seg(input t_state s);
        t_state so;
        so = s;
        so.hex = '0;
        so.dec = '0;
        so.dc  = '0;
        so.lz  = 1'b0;
        so.nd  = 1'b0;
        return so;
    endfunction

    // end of address: returns 1 on success, so carries pushed groups
    function automatic logic close_addr(input t_state s, output t_state so);
        logic good;
        so = s;
        good = 1'b1;
        if (!s.sc) begin
            good = s.dotted && (s.oi == 2'd3) && octet_ok(s);
            so.oct[3] = s.dec[7:0];
        end else if (s.cr == CR_LEAD) begin
            good = 1'b0;
        end else begin
            if (s.dotted) begin
                if ((s.oi != 2'd3) || !octet_ok(s) || (s.gc > 4'd6)) begin
                    good = 1'b0;
                end else begin
                    so.oct[3] = s.dec[7:0];
                    so = push(so, {so.oct[0], so.oct[1]});
                    so = push(so, {so.oct[2], so.oct[3]});
                end
            end else if (s.dc != 3'd0) begin
                if ((s.dc > 3'd4) || (s.gc >= 4'd8)) good = 1'b0;
                else so = push(so, s.hex);
            end else if (s.cr != CR_GAP) begin
                good = 1'b0;
            end
            if (good) good = so.gap ? (so.gc <= 4'd7) : (so.gc == 4'd8);
        end
        return good;
    endfunction

    function automatic t_state addr_char(input t_state s, input logic [7:0] c);
        t_state     so;
        t_state     sc;
        logic       hv;
        logic [3:0] h;
        logic [11:0] d;
        so = s;
        hv = 1'b1;
        h  = '0;
        d  = '0;
        if (c >= CH_ZERO && c <= CH_NINE) h = 4'(c - CH_ZERO);
        else if (c >= 8'h61 && c <= 8'h66) h = 4'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46) h = 4'(c - 8'h37);
        else hv = 1'b0;

        if (hv) begin
            if (s.cr == CR_LEAD) begin
                so.failed = 1'b1;
            end else begin
                so.cr = CR_NONE;
                if (s.dc == 3'd0) so.lz = (c == CH_ZERO);
                if (c > CH_NINE) begin
                    so.nd = 1'b1;
                end else if (s.dec < DEC_SAT) begin
                    d = 12'(s.dec) * 12'd10 + 12'(h);
                    so.dec = (d > 12'(DEC_SAT)) ? DEC_SAT : d[8:0];
                end
                if (s.dc < 3'd4) so.hex = {s.hex[11:0], h};
                if (s.dc < 3'd7) so.dc = s.dc + 3'd1;
            end
        end else if (c == CH_DOT) begin
            if (!octet_ok(s) || (s.oi == 2'd3)) begin
                so.failed = 1'b1;
            end else begin
                so.oct[s.oi] = s.dec[7:0];
                so.oi = s.oi + 2'd1;
                so.dotted = 1'b1;
                so = clear_seg(so);
            end
        end else if (c == CH_COLON) begin
            if (s.dotted) begin
                so.failed = 1'b1;
            end else begin
                so.sc = 1'b1;
                if (s.dc != 3'd0) begin
                    if ((s.dc > 3'd4) || (s.gc >= 4'd8)) begin
                        so.failed = 1'b1;
                    end else begin
                        so = push(so, s.hex);
                        so = clear_seg(so);
                        so.cr = CR_SINGLE;
                    end
                end else if (s.cr == CR_NONE) begin
                    so.cr = CR_LEAD;
                end else if (s.cr == CR_LEAD || s.cr == CR_SINGLE) begin
                    if (s.gap) begin
                        so.failed = 1'b1;
                    end else begin
                        so.gap = 1'b1;
                        so.gp  = s.gc;
                        so.cr  = CR_GAP;
                    end
                end else begin
                    so.failed = 1'b1;
                end
            end
        end else if (c == CH_SLASH) begin
            if (!close_addr(s, sc)) begin
                so.failed = 1'b1;
            end else begin
                so = sc;
                so.in_prefix = 1'b1;
            end
        end else begin
            so.failed = 1'b1;
        end
        return so;
    endfunction

    function automatic t_state pfx_char(input t_state s, input logic [7:0] c);
        t_state      so;
        logic [10:0] v;
        so = s;
        v = 11'(s.pa) * 11'd10 + 11'(c - CH_ZERO);
        if (c < CH_ZERO || c > CH_NINE) so.failed = 1'b1;
        else if (s.pd == 2'd3) so.failed = 1'b1;
        else if ((s.pd != 2'd0) && (s.pa == 8'd0)) so.failed = 1'b1;
        else if (v > 11'(PFX_MAX_V6)) so.failed = 1'b1;
        else begin
            so.pa = v[7:0];
            so.pd = s.pd + 2'd1;
        end
        return so;
    endfunction

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_take    = i_in_valid & ~o_in_stall;

    always_comb begin
        t_state      s;
        t_state      sc;
        logic [4:0]  ins;
        logic [4:0]  gend;
        logic [4:0]  ii;
        logic [2:0]  src;
        logic [7:0][15:0] g;
        s    = r_state;
        sc   = r_state;
        ins  = '0;
        gend = '0;
        ii   = '0;
        src  = '0;
        g    = '0;
        n_out = '0;

        if (!s.failed) begin
            if (s.in_prefix) s = pfx_char(s, i_in_data.ch);
            else s = addr_char(s, i_in_data.ch);
        end

        if (i_in_data.last) begin
            if (!s.failed) begin
                if (s.in_prefix) begin
                    if ((s.pd == 2'd0) || (s.pa > (s.sc ? PFX_MAX_V6 : PFX_MAX_V4)))
                        s.failed = 1'b1;
                end else if (!close_addr(s, sc)) begin
                    s.failed = 1'b1;
                end else begin
                    s = sc;
                end
            end
            // "::" expansion: groups after the gap shift right by the insert count
            ins  = s.gap ? (5'd8 - 5'(s.gc)) : 5'd0;
            gend = 5'(s.gp) + ins;
            for (int i = 0; i < 8; i++) begin
                ii  = 5'(i);
                src = 3'(ii - ins);
                if (!s.gap || ii < 5'(s.gp)) g[7-i] = s.grp[i];
                else if (ii < gend) g[7-i] = '0;
                else g[7-i] = s.grp[src];
            end
            if (!s.failed) begin
                n_out.ok          = 1'b1;
                n_out.is_v6       = s.sc;
                n_out.pfx_present = s.in_prefix;
                n_out.prefix_len  = s.in_prefix ? s.pa : 8'd0;
                if (s.sc) begin
                    n_out.addr_hi = g[7:4];
                    n_out.addr_lo = g[3:0];
                end else begin
                    n_out.addr_lo = {32'd0, s.oct[0], s.oct[1], s.oct[2], s.oct[3]};
                end
            end
            n_state = '0;
        end else begin
            n_state = s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) r_state <= n_state;
            if (in_take && i_in_data.last) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* src/ctp_checker.sv */
// Port-level checks for cidr_text_parser, bound to the top level.
// Depends on ctp_pkg and cidr_text_parser_defines.svh.
`timescale 1ns / 1ps
`include "cidr_text_parser_defines.svh"
module ctp_checker
    import ctp_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    `CTP_ASSERT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data), "held result changed")
    `CTP_ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")
    `CTP_ASSERT(a_stall, i_clk, i_rst_n, o_in_stall |-> o_out_valid && i_out_stall, "input stalled without a held result")
    `CTP_ASSERT(a_nolast, i_clk, i_rst_n, i_in_valid && !o_in_stall && !i_in_data.last && !(o_out_valid && i_out_stall) |=> !o_out_valid, "result without last character")
    `CTP_ASSERT(a_failz, i_clk, i_rst_n, o_out_valid && !o_out_data.ok |-> o_out_data.addr_hi == 64'd0 && o_out_data.addr_lo == 64'd0 && o_out_data.prefix_len == 8'd0 && !o_out_data.is_v6 && !o_out_data.pfx_present, "failed result not zero")

endmodule

bind cidr_text_parser ctp_checker u_ctp_checker (.*);
